// ===== design/ovn_pkg.sv =====
package ovn_pkg;

    // fixed field widths
    localparam int SEED_W     = 16;
    localparam int POS_W      = 10;
    localparam int OCT_CFG_W  = 4;
    localparam int BIAS_CFG_W = 3;

    // table length default
    localparam int NOISE_LENGTH_DEF = 1024;

    // weights are 2^(WEIGHT_TOP - bias_shift*octave)
    localparam int WEIGHT_TOP = 40;
    localparam int SH_W       = 8;
    localparam int SHAMT_W    = 6;

    localparam logic [BIAS_CFG_W-1:0] BIAS_MAX = 3'd4;

    // accumulator, weight sum and divider widths
    localparam int ACC_W  = 64;
    localparam int WSUM_W = 48;
    localparam int QUO_W  = 16;
    localparam int CNT_W  = $clog2(QUO_W + 1);

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [OCT_CFG_W-1:0]  OCT_CFG_RST  = 4'd8;
    localparam logic [BIAS_CFG_W-1:0] BIAS_CFG_RST = 3'd1;

    localparam logic REG_OCTAVE_COUNT = 1'b0;
    localparam logic REG_BIAS_SHIFT   = 1'b1;

    // opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        DIV_MOD,
        DIV_X,
        DIV_NUM,
        DIV_NORM
    } t_div_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_MOD_WAIT,
        ST_OCT,
        ST_XDIV_WAIT,
        ST_RD_A,
        ST_RD_B,
        ST_MUL,
        ST_SAMPLE,
        ST_SDIV_WAIT,
        ST_ACC,
        ST_NORM,
        ST_NORM_WAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic     capture;
        logic     seed_write;
        logic     div_start;
        t_div_sel div_sel;
        logic     x_from_div;
        logic     ad_pow2;
        logic     ad_from_div;
        logic     b_load;
        logic     rd_b;
        logic     mul_a;
        logic     mul_b;
        logic     samp_shift;
        logic     samp_from_div;
        logic     acc_en;
        logic     load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic div_busy;
        logic last_oct;
    } t_dp_stat;

endpackage

// ===== design/ovn_div.sv =====
module ovn_div import ovn_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ACC_W-1:0]  i_dividend,
    input  logic [WSUM_W-1:0] i_divisor,
    output logic              o_busy,
    output logic [QUO_W-1:0]  o_quotient,
    output logic [ACC_W-1:0]  o_remainder
);

    // restoring divider, one quotient bit per cycle
    // quotient must fit in QUO_W bits
    logic [ACC_W-1:0] r_rem;
    logic [ACC_W-1:0] r_den;
    logic [QUO_W-1:0] r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(QUO_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_den <= ACC_W'(i_divisor) << (QUO_W - 1);
            r_q   <= '0;
        end else if (r_busy) begin
            if (r_rem >= r_den) begin
                r_rem <= r_rem - r_den;
                r_q   <= {r_q[QUO_W-2:0], 1'b1};
            end else begin
                r_q   <= {r_q[QUO_W-2:0], 1'b0};
            end
            r_den <= r_den >> 1;
        end
    end

    assign o_busy      = r_busy;
    assign o_quotient  = r_q;
    assign o_remainder = r_rem;

endmodule

// ===== design/ovn_dp.sv =====
module ovn_dp import ovn_pkg::*; #(
    parameter int NOISE_LENGTH = NOISE_LENGTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic [POS_W-1:0]      i_position,
    input  logic [SEED_W-1:0]     i_seed_value,
    input  logic [OCT_CFG_W-1:0]  i_octave_count,
    input  logic [BIAS_CFG_W-1:0] i_bias_shift,
    output logic [SEED_W-1:0]     o_noise_value,
    output logic [POS_W-1:0]      o_query_position
);

    localparam int AW    = $clog2(NOISE_LENGTH);
    localparam int KMAX  = $clog2(NOISE_LENGTH + 1) - 1;
    localparam int OW    = $clog2(KMAX + 1);
    localparam int PW    = $clog2(NOISE_LENGTH + 1);
    localparam int NW    = PW + SEED_W;
    localparam int BW    = PW + 1;
    localparam int EXT_W = (AW > POS_W) ? AW : POS_W;

    // seed table
    logic [SEED_W-1:0] r_mem [NOISE_LENGTH];
    logic [SEED_W-1:0] r_rd;

    logic [POS_W-1:0]      r_pos;
    logic [AW-1:0]         r_x;
    logic [AW-1:0]         r_a;
    logic [AW-1:0]         r_b;
    logic [AW-1:0]         r_d;
    logic [OW-1:0]         r_o;
    logic [OW-1:0]         r_k;
    logic [BIAS_CFG_W-1:0] r_s;
    logic [NW-1:0]         r_num;
    logic [SEED_W-1:0]     r_sample;
    logic [ACC_W-1:0]      r_acc;
    logic [WSUM_W-1:0]     r_wsum;
    logic [SEED_W-1:0]     r_noise;
    logic [POS_W-1:0]      r_qpos;

    logic [EXT_W-1:0]      wr_ext;
    logic [AW-1:0]         wr_addr;
    logic                  wr_in_range;
    logic [AW-1:0]         rd_addr;
    logic [OW-1:0]         k_eff;
    logic [BIAS_CFG_W-1:0] s_eff;
    logic [PW-1:0]         pitch;
    logic [AW-1:0]         d_pow2;
    logic [BW-1:0]         sum_ab;
    logic [AW-1:0]         b_next;
    logic [SH_W-1:0]       sh;
    logic                  w_on;
    logic [SHAMT_W-1:0]    shamt;

    logic                  div_busy;
    logic [QUO_W-1:0]      div_q;
    logic [ACC_W-1:0]      div_r;
    logic [ACC_W-1:0]      div_dividend;
    logic [WSUM_W-1:0]     div_divisor;

    // write address and table-length check
    assign wr_ext      = EXT_W'(i_position);
    assign wr_addr     = wr_ext[AW-1:0];
    assign wr_in_range = (32'(i_position) < NOISE_LENGTH);

    assign rd_addr = i_cmd.rd_b ? r_b : r_a;

    always_ff @(posedge i_clk) begin
        if (i_cmd.seed_write && wr_in_range) begin
            r_mem[wr_addr] <= i_seed_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[rd_addr];
    end

    // octave count and bias saturation
    always_comb begin
        if (i_octave_count == '0) begin
            k_eff = OW'(1);
        end else if (32'(i_octave_count) > KMAX) begin
            k_eff = OW'(KMAX);
        end else begin
            k_eff = OW'(i_octave_count);
        end
        s_eff = (i_bias_shift > BIAS_MAX) ? BIAS_MAX : i_bias_shift;
    end

    assign pitch  = PW'(NOISE_LENGTH) >> r_o;
    assign d_pow2 = r_x & AW'(pitch - PW'(1));

    // neighbor sample, wraps at the table length
    assign sum_ab = BW'(r_a) + BW'(pitch);
    assign b_next = (sum_ab >= BW'(NOISE_LENGTH)) ? AW'(sum_ab - BW'(NOISE_LENGTH))
                                                  : AW'(sum_ab);

    // octave weight exponent
    assign sh    = SH_W'(r_s) * SH_W'(r_o);
    assign w_on  = (sh <= SH_W'(WEIGHT_TOP));
    assign shamt = SHAMT_W'(SH_W'(WEIGHT_TOP) - sh);

    always_comb begin
        case (i_cmd.div_sel)
            DIV_MOD: begin
                div_dividend = ACC_W'(r_pos);
                div_divisor  = WSUM_W'(NOISE_LENGTH);
            end
            DIV_X: begin
                div_dividend = ACC_W'(r_x);
                div_divisor  = WSUM_W'(pitch);
            end
            DIV_NUM: begin
                div_dividend = ACC_W'(r_num);
                div_divisor  = WSUM_W'(pitch);
            end
            default: begin
                div_dividend = r_acc;
                div_divisor  = r_wsum;
            end
        endcase
    end

    ovn_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_busy      (div_busy),
        .o_quotient  (div_q),
        .o_remainder (div_r)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pos  <= i_position;
            r_x    <= wr_ext[AW-1:0];
            r_k    <= k_eff;
            r_s    <= s_eff;
            r_o    <= '0;
            r_acc  <= '0;
            r_wsum <= '0;
        end
        if (i_cmd.x_from_div) begin
            r_x <= AW'(div_r);
        end
        if (i_cmd.ad_pow2) begin
            r_d <= d_pow2;
            r_a <= r_x - d_pow2;
        end
        if (i_cmd.ad_from_div) begin
            r_d <= AW'(div_r);
            r_a <= r_x - AW'(div_r);
        end
        if (i_cmd.b_load) begin
            r_b <= b_next;
        end
        // r_rd holds seed at a here, then seed at b in the next cycle
        if (i_cmd.mul_a) begin
            r_num <= NW'(pitch - PW'(r_d)) * NW'(r_rd);
        end
        if (i_cmd.mul_b) begin
            r_num <= r_num + NW'(r_d) * NW'(r_rd);
        end
        if (i_cmd.samp_shift) begin
            r_sample <= SEED_W'(r_num >> (OW'(KMAX) - r_o));
        end
        if (i_cmd.samp_from_div) begin
            r_sample <= div_q;
        end
        if (i_cmd.acc_en) begin
            if (w_on) begin
                r_acc  <= r_acc + (ACC_W'(r_sample) << shamt);
                r_wsum <= r_wsum + (WSUM_W'(1) << shamt);
            end
            r_o <= r_o + OW'(1);
        end
        if (i_cmd.load_out) begin
            r_noise <= div_q;
            r_qpos  <= r_pos;
        end
    end

    assign o_stat.div_busy = div_busy;
    assign o_stat.last_oct = (({1'b0, r_o} + {{OW{1'b0}}, 1'b1}) == {1'b0, r_k});

    assign o_noise_value    = r_noise;
    assign o_query_position = r_qpos;

endmodule

// ===== design/ovn_ctrl.sv =====
module ovn_ctrl import ovn_pkg::*; #(
    parameter int NOISE_LENGTH = NOISE_LENGTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  logic     i_opcode,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    // power-of-two lengths take pitch steps by shift and mask
    localparam bit POW2 = ((NOISE_LENGTH & (NOISE_LENGTH - 1)) == 0);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   in_xfer;

    assign in_xfer = i_in_valid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer && (i_opcode == OP_QUERY)) begin
                    n_state = POW2 ? ST_OCT : ST_MOD;
                end
            end
            ST_MOD:       n_state = ST_MOD_WAIT;
            ST_MOD_WAIT:  if (!i_stat.div_busy) n_state = ST_OCT;
            ST_OCT:       n_state = POW2 ? ST_RD_A : ST_XDIV_WAIT;
            ST_XDIV_WAIT: if (!i_stat.div_busy) n_state = ST_RD_A;
            ST_RD_A:      n_state = ST_RD_B;
            ST_RD_B:      n_state = ST_MUL;
            ST_MUL:       n_state = ST_SAMPLE;
            ST_SAMPLE:    n_state = POW2 ? ST_ACC : ST_SDIV_WAIT;
            ST_SDIV_WAIT: if (!i_stat.div_busy) n_state = ST_ACC;
            ST_ACC:       n_state = i_stat.last_oct ? ST_NORM : ST_OCT;
            ST_NORM:      n_state = ST_NORM_WAIT;
            ST_NORM_WAIT: if (!i_stat.div_busy) n_state = ST_OUT;
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.div_sel = DIV_NORM;
        case (r_state)
            ST_IDLE: begin
                o_cmd.capture    = in_xfer && (i_opcode == OP_QUERY);
                o_cmd.seed_write = in_xfer && (i_opcode == OP_WRITE);
            end
            ST_MOD: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_MOD;
            end
            ST_MOD_WAIT: begin
                o_cmd.x_from_div = !i_stat.div_busy;
            end
            ST_OCT: begin
                o_cmd.ad_pow2   = POW2;
                o_cmd.div_start = !POW2;
                o_cmd.div_sel   = DIV_X;
            end
            ST_XDIV_WAIT: begin
                o_cmd.ad_from_div = !i_stat.div_busy;
            end
            ST_RD_A: begin
                o_cmd.b_load = 1'b1;
            end
            ST_RD_B: begin
                o_cmd.rd_b  = 1'b1;
                o_cmd.mul_a = 1'b1;
            end
            ST_MUL: begin
                o_cmd.mul_b = 1'b1;
            end
            ST_SAMPLE: begin
                o_cmd.samp_shift = POW2;
                o_cmd.div_start  = !POW2;
                o_cmd.div_sel    = DIV_NUM;
            end
            ST_SDIV_WAIT: begin
                o_cmd.samp_from_div = !i_stat.div_busy;
            end
            ST_ACC: begin
                o_cmd.acc_en = 1'b1;
            end
            ST_NORM: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_NORM;
            end
            ST_OUT: begin
                o_cmd.load_out = !r_out_valid || i_out_ready;
            end
            default: begin
                o_cmd.capture = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== design/octave_value_noise_1d.sv =====
// channel | direction | handshake              | payload
// --------+-----------+------------------------+-------------------------------------
// in      | input     | i_in_valid/o_in_ready  | i_opcode, i_position, i_seed_value
// out     | output    | o_out_valid/i_out_ready| o_noise_value, o_query_position
// cfg     | input     | psel/penable/pwrite    | paddr, pwdata, prdata (pready tied high)
//
// a seed write is taken in the idle state; a query runs the per-octave
// read/multiply/accumulate loop over the K effective octaves and then the
// 16-step divider used for normalizing; table lengths that are not a power of
// two also run the position modulo and the per-octave pitch divisions through
// that divider
// reset is synchronous active low, clears control state and sets the config regs to 8 and 1;
// the seed table holds garbage until written
// a finished result waits in the output register while the next item is taken

module octave_value_noise_1d import ovn_pkg::*; #(
    parameter int NOISE_LENGTH = NOISE_LENGTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // item input
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_opcode,
    input  logic [POS_W-1:0]  i_position,
    input  logic [SEED_W-1:0] i_seed_value,
    // result output
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [SEED_W-1:0] o_noise_value,
    output logic [POS_W-1:0]  o_query_position,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [OCT_CFG_W-1:0]  r_octave_count;
    logic [BIAS_CFG_W-1:0] r_bias_shift;
    logic                  cfg_wr;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // register writes complete on the access phase, no wait states
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octave_count <= OCT_CFG_RST;
            r_bias_shift   <= BIAS_CFG_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_OCTAVE_COUNT: r_octave_count <= pwdata[OCT_CFG_W-1:0];
                REG_BIAS_SHIFT:   r_bias_shift   <= pwdata[BIAS_CFG_W-1:0];
                default:          r_bias_shift   <= r_bias_shift;
            endcase
        end
    end

    // readback of raw register values, saturation happens per query
    always_comb begin
        case (paddr[2])
            REG_OCTAVE_COUNT: prdata = APB_DW'(r_octave_count);
            REG_BIAS_SHIFT:   prdata = APB_DW'(r_bias_shift);
            default:          prdata = '0;
        endcase
    end

    // sequencer: one query at a time, walks the octaves and the divider
    ovn_ctrl #(
        .NOISE_LENGTH (NOISE_LENGTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (dp_cmd),
        .i_stat      (dp_stat)
    );

    // seed table, interpolation, weighted sum and normalizing divider
    ovn_dp #(
        .NOISE_LENGTH (NOISE_LENGTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat),
        .i_position       (i_position),
        .i_seed_value     (i_seed_value),
        .i_octave_count   (r_octave_count),
        .i_bias_shift     (r_bias_shift),
        .o_noise_value    (o_noise_value),
        .o_query_position (o_query_position)
    );

endmodule
